// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL, included by number_literal_to_word.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ----- hw/rtl/nlw_pkg.sv -----
package nlw_pkg;

   // Character codes
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_X     = 8'h78;
   localparam logic [7:0] CHAR_LOW_A = 8'h61;
   localparam logic [7:0] CHAR_LOW_F = 8'h66;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_F  = 8'h46;

   // Offsets from character code to digit value
   localparam logic [7:0] DEC_OFFSET   = 8'd48;
   localparam logic [7:0] LOWER_OFFSET = 8'd87;
   localparam logic [7:0] UPPER_OFFSET = 8'd55;

   // Widths and limits
   localparam int unsigned MAG_W  = 17;
   localparam int unsigned WORD_W = 16;
   localparam int unsigned PROD_W = MAG_W + 5;
   localparam logic [MAG_W-1:0] MAG_CAP      = 17'h1FFFF;
   localparam logic [MAG_W-1:0] MAX_POSITIVE = 17'd65535;
   localparam logic [MAG_W-1:0] MAX_NEG_MAG  = 17'd32768;

   // Character position
   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_THIRD  = 2'd2;
   localparam logic [1:0] POS_LATER  = 2'd3;

   // Result status codes
   localparam logic [1:0] ST_ACCEPTED = 2'd0;
   localparam logic [1:0] ST_RANGE    = 2'd1;
   localparam logic [1:0] ST_UNKNOWN  = 2'd2;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } digit_type;

   // Digit value of a character in decimal or hex
   function automatic digit_type digit_of(input logic [7:0] c, input logic hex);
      digit_type d;
      logic [7:0] diff;
      d    = '0;
      diff = '0;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         diff = c - DEC_OFFSET;
         d.valid = 1'b1;
      end else if (hex && c >= CHAR_LOW_A && c <= CHAR_LOW_F) begin
         diff = c - LOWER_OFFSET;
         d.valid = 1'b1;
      end else if (hex && c >= CHAR_UP_A && c <= CHAR_UP_F) begin
         diff = c - UPPER_OFFSET;
         d.valid = 1'b1;
      end
      d.value = diff[3:0];
      return d;
   endfunction

endpackage

// ----- hw/rtl/number_literal_to_word.sv -----
// Number literal to word: takes the characters of one token, one request per
// cycle with req_last_char marking the final one, and returns one result per
// token: the 16-bit word for a decimal or 0x-prefixed hex literal with optional
// minus sign, plus a status (accepted, out of range, unknown). The digit
// accumulate (multiply by 10 or 16, add) sits between the parse state registers
// and is updated on every accepted request. The result appears in the output
// register the cycle after the last character is accepted. While a result sits
// in the output register and rsp_ready is low, req_ready is low and no
// character is taken; when the result is taken in a cycle, a new request is
// accepted in that same cycle, so with rsp_ready held high one character is
// accepted every cycle.
`include "assert_macros.svh"

module number_literal_to_word (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_char_code,
   input  logic                          req_last_char,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [nlw_pkg::WORD_W-1:0]    rsp_word_value,
   output logic [1:0]                    rsp_status
);
   import nlw_pkg::*;

   logic [1:0]        pos_ff, pos_in;
   logic              first_zero_ff, first_zero_in;
   logic              hex_ff, hex_in;
   logic              neg_ff, neg_in;
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic              bad_ff, bad_in;
   logic              ovf_ff, ovf_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [1:0]        status_ff, status_in;

   logic              accept;
   logic              take;
   digit_type         digit;
   logic [PROD_W-1:0] prod;
   logic [MAG_W-1:0]  neg_mag;

   // Accept while the output register is empty or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Parse one character
   always_comb begin
      first_zero_in = first_zero_ff;
      hex_in        = hex_ff;
      neg_in        = neg_ff;
      mag_in        = mag_ff;
      bad_in        = bad_ff;
      ovf_in        = ovf_ff;
      take          = 1'b1;
      digit         = digit_of(req_char_code, hex_ff);
      if (hex_ff) begin
         prod = {1'b0, mag_ff, 4'b0000} + {{(PROD_W-4){1'b0}}, digit.value};
      end else begin
         prod = {2'b00, mag_ff, 3'b000} + {4'b0000, mag_ff, 1'b0}
              + {{(PROD_W-4){1'b0}}, digit.value};
      end

      if (pos_ff == POS_FIRST) begin
         first_zero_in = (req_char_code == CHAR_ZERO);
         if (req_char_code == CHAR_MINUS) begin
            neg_in = 1'b1;
            take   = 1'b0;
         end
      end else if (pos_ff == POS_SECOND && first_zero_ff && req_char_code == CHAR_X) begin
         hex_in = 1'b1;
         take   = 1'b0;
      end else if (pos_ff == POS_THIRD && hex_ff && req_char_code == CHAR_MINUS) begin
         neg_in = 1'b1;
         take   = 1'b0;
      end

      // Accumulate the digit, flag an invalid one, cap on overflow
      if (take) begin
         if (!digit.valid) begin
            bad_in = 1'b1;
         end else if (prod > {{(PROD_W-MAG_W){1'b0}}, MAG_CAP}) begin
            ovf_in = 1'b1;
            mag_in = MAG_CAP;
         end else begin
            mag_in = prod[MAG_W-1:0];
         end
      end

      pos_in = (pos_ff == POS_LATER) ? POS_LATER : pos_ff + 2'd1;
   end

   // Form the result from the updated parse state
   always_comb begin
      word_in = '0;
      neg_mag = '0 - mag_in;
      if (bad_in || mag_in == '0) begin
         status_in = first_zero_in ? ST_ACCEPTED : ST_UNKNOWN;
      end else if (ovf_in || (neg_in ? (mag_in > MAX_NEG_MAG) : (mag_in > MAX_POSITIVE))) begin
         status_in = ST_RANGE;
      end else begin
         status_in = ST_ACCEPTED;
         word_in   = neg_in ? neg_mag[WORD_W-1:0] : mag_in[WORD_W-1:0];
      end
   end

   assign rsp_valid_in = (accept && req_last_char) || (rsp_valid_ff && !rsp_ready);

   // Advance parse state; clear it on reset and after the last character
   always_ff @(posedge clock) begin
      if (reset || (accept && req_last_char)) begin
         pos_ff        <= POS_FIRST;
         first_zero_ff <= 1'b0;
         hex_ff        <= 1'b0;
         neg_ff        <= 1'b0;
         mag_ff        <= '0;
         bad_ff        <= 1'b0;
         ovf_ff        <= 1'b0;
      end else if (accept) begin
         pos_ff        <= pos_in;
         first_zero_ff <= first_zero_in;
         hex_ff        <= hex_in;
         neg_ff        <= neg_in;
         mag_ff        <= mag_in;
         bad_ff        <= bad_in;
         ovf_ff        <= ovf_in;
      end
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_last_char) begin
         word_ff   <= word_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_word_value = word_ff;
   assign rsp_status     = status_ff;

   `ASSERT_IMPLY(a_word_zero_unless_ok, clock, reset,
      rsp_valid_ff && status_ff != ST_ACCEPTED, word_ff == '0)
   `ASSERT_NEXT(a_last_clears, clock, reset,
      accept && req_last_char, rsp_valid_ff && pos_ff == POS_FIRST && mag_ff == '0)
   `ASSERT_IMPLY(a_ovf_capped, clock, reset, ovf_ff, mag_ff == MAG_CAP)
   `ASSERT_IMPLY(a_hex_needs_zero, clock, reset, hex_ff, first_zero_ff)

endmodule
